/* design/icv6er_pkg.sv */
// Shared constants and types for the ICMPv6 echo responder.
`default_nettype none
package icv6er_pkg;
	localparam logic [15:0] ETHERTYPE_V6        = 16'h86DD;
	localparam logic [7:0]  NEXT_HDR_ICMP       = 8'd58;
	localparam logic [7:0]  ICMP_TYPE_REQ       = 8'd128;
	localparam logic [7:0]  ICMP_TYPE_RPL       = 8'd129;
	localparam logic [15:0] ECHO_REQUEST_WORD   = 16'h8000;
	localparam logic [15:0] ECHO_REPLY_WORD     = 16'h8100;
	localparam int          MAC_ADDR_BYTES      = 6;
	localparam int          HDR_BYTES           = 62;
	localparam int          POS_W               = 6;

	localparam logic [POS_W-1:0] HDR_LAST   = POS_W'(HDR_BYTES - 1);
	localparam logic [POS_W-1:0] POS_ETYPE0 = 6'd12;
	localparam logic [POS_W-1:0] POS_ETYPE1 = 6'd13;
	localparam logic [POS_W-1:0] POS_NXTHDR = 6'd20;
	localparam logic [POS_W-1:0] POS_TYPE   = 6'd54;
	localparam logic [POS_W-1:0] POS_CSUM0  = 6'd56;
	localparam logic [POS_W-1:0] POS_CSUM1  = 6'd57;

	localparam logic [2:0] REASON_NONE      = 3'd0;
	localparam logic [2:0] REASON_SHORT     = 3'd1;
	localparam logic [2:0] REASON_NOT_IPV6  = 3'd2;
	localparam logic [2:0] REASON_NOT_ICMP  = 3'd3;
	localparam logic [2:0] REASON_NOT_ECHO  = 3'd4;
	localparam logic [2:0] REASON_NO_SLOT   = 3'd5;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [7:0]  next_hdr;
		logic [7:0]  icmp_type;
		logic [15:0] csum;
	} icv6er_fields_t;

	typedef struct packed {
		logic [2:0]  reason;
		logic [15:0] csum;
	} icv6er_decision_t;
endpackage
`default_nettype wire

/* design/icv6er_check.sv */
// Header qualification and incremental checksum patch.
`default_nettype none
module icv6er_check (
	input  icv6er_pkg::icv6er_fields_t   fields,
	input  logic                         tx_slot_free,
	output icv6er_pkg::icv6er_decision_t decision
);
	import icv6er_pkg::*;

	logic [16:0] sum_a;
	logic [15:0] fold_a;
	logic [16:0] sum_b;
	logic [15:0] fold_b;

	always_comb begin
		sum_a  = {1'b0, ~fields.csum} + {1'b0, ~ECHO_REQUEST_WORD};
		fold_a = sum_a[15:0] + {15'd0, sum_a[16]};
		sum_b  = {1'b0, fold_a} + {1'b0, ECHO_REPLY_WORD};
		fold_b = sum_b[15:0] + {15'd0, sum_b[16]};
		decision.csum = ~fold_b;
		if (fields.ethertype != ETHERTYPE_V6) begin
			decision.reason = REASON_NOT_IPV6;
		end else if (fields.next_hdr != NEXT_HDR_ICMP) begin
			decision.reason = REASON_NOT_ICMP;
		end else if (fields.icmp_type != ICMP_TYPE_REQ) begin
			decision.reason = REASON_NOT_ECHO;
		end else if (!tx_slot_free) begin
			decision.reason = REASON_NO_SLOT;
		end else begin
			decision.reason = REASON_NONE;
		end
	end
endmodule
`default_nettype wire

/* design/icmpv6_echo_responder.sv */
// ICMPv6 echo responder top level: header buffer, reply burst and pass-through.
//
// Input channel (in_valid/in_ready) carries one frame byte per beat with
// last_byte on the final byte; tx_slot_free is sampled on the 62nd byte.
// Output channel (out_valid/out_ready) carries one result per beat.
// Header bytes 0..60 give no result, but a last_byte among them gives a
// short drop beat. At the 62nd byte the frame is judged: a reject gives
// one drop beat in the next cycle. A reply streams 62 header bytes (a RAM
// read, then a load of the output register, per beat), during which input
// is held off. Payload bytes then pass through the output register, one
// per cycle while out_ready allows. Bytes after a drop are swallowed.
// The output register holds its beat while out_ready is low; input is
// taken only when that register is empty or being drained.
// Reset returns to the start of a frame with no output pending; the header
// RAM needs no clearing since every entry is written before it is read.
`default_nettype none
module icmpv6_echo_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       tx_slot_free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       result_kind,
	output logic [2:0] drop_reason
);
	import icv6er_pkg::*;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_BURST_RD = 3'd1;
	localparam logic [2:0] ST_BURST_WR = 3'd2;
	localparam logic [2:0] ST_FORWARD = 3'd3;
	localparam logic [2:0] ST_DISCARD = 3'd4;

	function automatic logic [POS_W-1:0] reply_addr(input logic [POS_W-1:0] i);
		logic [POS_W-1:0] a;
		a = i;
		if (i < POS_W'(MAC_ADDR_BYTES)) begin
			a = i + POS_W'(MAC_ADDR_BYTES);
		end else if (i < POS_W'(2 * MAC_ADDR_BYTES)) begin
			a = i - POS_W'(MAC_ADDR_BYTES);
		end else if (i >= 6'd22 && i < 6'd38) begin
			a = i + 6'd16;
		end else if (i >= 6'd38 && i < 6'd54) begin
			a = i - 6'd16;
		end
		return a;
	endfunction

	logic [7:0]       hdr_mem [HDR_BYTES];
	logic [7:0]       rd_data_q;
	logic [2:0]       state_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] idx_q;
	logic             burst_last_q;
	logic [15:0]      csum_q;
	icv6er_fields_t   fields_q;
	icv6er_decision_t decision;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_kind_q;
	logic [2:0]       out_reason_q;

	logic             out_free;
	logic             accept;
	logic             rd_en;
	logic             load;
	logic [7:0]       load_byte;
	logic             load_last;
	logic             load_kind;
	logic [2:0]       load_reason;
	logic [2:0]       state_d;

	icv6er_check u_check (
		.fields       (fields_q),
		.tx_slot_free (tx_slot_free),
		.decision     (decision)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = out_free &&
		(state_q == ST_COLLECT || state_q == ST_FORWARD || state_q == ST_DISCARD);
	assign accept = in_valid && in_ready;
	assign rd_en = (state_q == ST_BURST_RD) && out_free;

	always_comb begin
		state_d     = state_q;
		load        = 1'b0;
		load_byte   = 8'd0;
		load_last   = 1'b1;
		load_kind   = KIND_DROP;
		load_reason = REASON_NONE;
		case (state_q)
			ST_COLLECT: begin
				if (accept) begin
					if (pos_q != HDR_LAST) begin
						if (last_byte) begin
							load        = 1'b1;
							load_reason = REASON_SHORT;
						end
					end else if (decision.reason != REASON_NONE) begin
						load        = 1'b1;
						load_reason = decision.reason;
						state_d     = last_byte ? ST_COLLECT : ST_DISCARD;
					end else begin
						state_d = ST_BURST_RD;
					end
				end
			end
			ST_BURST_RD: begin
				if (rd_en) begin
					state_d = ST_BURST_WR;
				end
			end
			ST_BURST_WR: begin
				load      = 1'b1;
				load_kind = KIND_DATA;
				load_last = (idx_q == HDR_LAST) && burst_last_q;
				case (idx_q)
					POS_TYPE:  load_byte = ICMP_TYPE_RPL;
					POS_CSUM0: load_byte = csum_q[15:8];
					POS_CSUM1: load_byte = csum_q[7:0];
					default:   load_byte = rd_data_q;
				endcase
				if (idx_q == HDR_LAST) begin
					state_d = burst_last_q ? ST_COLLECT : ST_FORWARD;
				end else begin
					state_d = ST_BURST_RD;
				end
			end
			ST_FORWARD: begin
				if (accept) begin
					load      = 1'b1;
					load_kind = KIND_DATA;
					load_byte = data_byte;
					load_last = last_byte;
					if (last_byte) begin
						state_d = ST_COLLECT;
					end
				end
			end
			ST_DISCARD: begin
				if (accept && last_byte) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && state_q == ST_COLLECT) begin
			hdr_mem[pos_q] <= data_byte;
		end
		if (rd_en) begin
			rd_data_q <= hdr_mem[reply_addr(idx_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && state_q == ST_COLLECT) begin
			case (pos_q)
				POS_ETYPE0: fields_q.ethertype[15:8] <= data_byte;
				POS_ETYPE1: fields_q.ethertype[7:0]  <= data_byte;
				POS_NXTHDR: fields_q.next_hdr        <= data_byte;
				POS_TYPE:   fields_q.icmp_type       <= data_byte;
				POS_CSUM0:  fields_q.csum[15:8]      <= data_byte;
				POS_CSUM1:  fields_q.csum[7:0]       <= data_byte;
				default: ;
			endcase
			if (pos_q == HDR_LAST) begin
				csum_q       <= decision.csum;
				burst_last_q <= last_byte;
			end
		end
		if (load) begin
			out_byte_q   <= load_byte;
			out_last_q   <= load_last;
			out_kind_q   <= load_kind;
			out_reason_q <= load_reason;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && state_q == ST_COLLECT) begin
				pos_q <= (last_byte || pos_q == HDR_LAST) ? '0 : pos_q + 1'b1;
			end
			if (accept && state_q == ST_COLLECT && pos_q == HDR_LAST) begin
				idx_q <= '0;
			end else if (state_q == ST_BURST_WR) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign out_last    = out_last_q;
	assign result_kind = out_kind_q;
	assign drop_reason = out_reason_q;
endmodule
`default_nettype wire

/* design/icv6er_checker.sv */
// Port-level assertions for the ICMPv6 echo responder, bound to the top level.
`default_nettype none
module icv6er_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       result_kind,
	input logic [2:0] drop_reason
);
	import icv6er_pkg::*;

	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DROP |->
			out_last && out_byte == 8'd0 && drop_reason != REASON_NONE)
		else $error("drop beat malformed");

	a_data_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DATA |-> drop_reason == REASON_NONE)
		else $error("reason on data beat");

	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drop_reason <= REASON_NO_SLOT)
		else $error("reason code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output beat changed while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
endmodule

bind icmpv6_echo_responder icv6er_checker u_icv6er_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_byte    (out_byte),
	.out_last    (out_last),
	.result_kind (result_kind),
	.drop_reason (drop_reason)
);
`default_nettype wire

/* verif/icmpv6_echo_responder_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ICMPv6 echo responder.
module icmpv6_echo_responder_test;
	import icv6er_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ITEM_TARGET  = 220;
	localparam int IP6_SRC_AT   = 22;
	localparam int IP6_ADDR_LEN = 16;
	localparam int FLAW_ETYPE    = 1;
	localparam int FLAW_NEXT_HDR = 2;
	localparam int FLAW_TYPE     = 4;
	localparam int CSUM_RANDOM   = -1;

	typedef struct packed {
		logic [7:0] octet;
		logic       eof;
		logic       kind;
		logic [2:0] reason;
	} echo_beat_t;

	class echo_scoreboard;
		logic [7:0] header [HDR_BYTES];
		logic [6:0] hdr_count;
		bit         passing;
		bit         swallowing;
		echo_beat_t reply_beats[$];
		int         mismatches;

		function new();
			mismatches = 0;
			end_of_frame();
		endfunction

		function void end_of_frame();
			hdr_count = '0;
			passing = 0;
			swallowing = 0;
		endfunction

		function logic [15:0] ones_sum(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		function logic [7:0] reply_octet(int i, logic [15:0] csum);
			if (i < MAC_ADDR_BYTES) return header[i + MAC_ADDR_BYTES];
			if (i < 2 * MAC_ADDR_BYTES) return header[i - MAC_ADDR_BYTES];
			if (i >= IP6_SRC_AT && i < IP6_SRC_AT + IP6_ADDR_LEN)
				return header[i + IP6_ADDR_LEN];
			if (i >= IP6_SRC_AT + IP6_ADDR_LEN && i < IP6_SRC_AT + 2 * IP6_ADDR_LEN)
				return header[i - IP6_ADDR_LEN];
			if (i == POS_TYPE) return ICMP_TYPE_RPL;
			if (i == POS_CSUM0) return csum[15:8];
			if (i == POS_CSUM1) return csum[7:0];
			return header[i];
		endfunction

		// one accepted input beat in, zero or more expected output beats queued
		function void take_frame_byte(logic [7:0] b, logic eof, logic slot);
			logic [2:0]  why;
			logic [15:0] csum;
			int          i;
			if (passing) begin
				reply_beats.push_back(echo_beat_t'({b, eof, KIND_DATA, REASON_NONE}));
				if (eof) end_of_frame();
				return;
			end
			if (swallowing) begin
				if (eof) end_of_frame();
				return;
			end
			if (hdr_count < HDR_BYTES) header[hdr_count[5:0]] = b;
			hdr_count++;
			if (hdr_count < HDR_BYTES) begin
				if (eof) begin
					reply_beats.push_back(echo_beat_t'({8'h00, 1'b1, KIND_DROP, REASON_SHORT}));
					end_of_frame();
				end
				return;
			end
			if ({header[POS_ETYPE0], header[POS_ETYPE1]} != ETHERTYPE_V6)
				why = REASON_NOT_IPV6;
			else if (header[POS_NXTHDR] != NEXT_HDR_ICMP)
				why = REASON_NOT_ICMP;
			else if (header[POS_TYPE] != ICMP_TYPE_REQ)
				why = REASON_NOT_ECHO;
			else if (!slot)
				why = REASON_NO_SLOT;
			else
				why = REASON_NONE;
			if (why != REASON_NONE) begin
				reply_beats.push_back(echo_beat_t'({8'h00, 1'b1, KIND_DROP, why}));
				if (eof) end_of_frame();
				else swallowing = 1;
				return;
			end
			// incremental update: request word out, reply word in
			csum = ~ones_sum(ones_sum(~{header[POS_CSUM0], header[POS_CSUM1]},
				~ECHO_REQUEST_WORD), ECHO_REPLY_WORD);
			for (i = 0; i < HDR_BYTES; i++)
				reply_beats.push_back(echo_beat_t'({reply_octet(i, csum),
					(i == HDR_BYTES - 1) ? eof : 1'b0, KIND_DATA, REASON_NONE}));
			if (eof) end_of_frame();
			else passing = 1;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40) $display("%0t mismatch: %s", $time, what);
		endtask

		task check_beat(echo_beat_t got);
			echo_beat_t want;
			if (reply_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat byte %02h last %0b kind %0b reason %0d",
					got.octet, got.eof, got.kind, got.reason));
				return;
			end
			want = reply_beats.pop_front();
			if (got.octet !== want.octet)
				report_mismatch($sformatf("out_byte %02h, want %02h", got.octet, want.octet));
			if (got.eof !== want.eof)
				report_mismatch($sformatf("out_last %0b, want %0b", got.eof, want.eof));
			if (got.kind !== want.kind)
				report_mismatch($sformatf("result_kind %0b, want %0b", got.kind, want.kind));
			if (got.reason !== want.reason)
				report_mismatch($sformatf("drop_reason %0d, want %0d", got.reason, want.reason));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       tx_slot_free;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       result_kind;
	logic [2:0] drop_reason;

	echo_scoreboard sb = new();
	bit src_quiet;
	bit sink_quiet;
	bit hold_request;
	int cycle_count = 0;

	icmpv6_echo_responder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.tx_slot_free(tx_slot_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last),
		.result_kind(result_kind),
		.drop_reason(drop_reason)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(echo_beat_t'({out_byte, out_last, result_kind, drop_reason}));
	end

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] other_than(logic [7:0] v);
		logic [7:0] r;
		do r = 8'($urandom); while (r == v);
		return r;
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int held;
		out_ready = 1'b0;
		stall_left = 0;
		sink_quiet = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
				hold_request = 0;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 49) == 0) sink_quiet = !sink_quiet;
				stall_left = pick_gap(sink_quiet);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic eof, logic slot);
		int gap;
		gap = pick_gap(src_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			last_byte <= 1'($urandom);
			tx_slot_free <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= eof;
		tx_slot_free <= slot;
		do @(posedge clk); while (!in_ready);
		sb.take_frame_byte(b, eof, slot);
	endtask

	// builds an echo request, breaks the fields named in flaws, sends len bytes
	task automatic send_frame(int len, int flaws, logic slot, int csum);
		logic [7:0] frame [];
		int n;
		int i;
		n = (len > HDR_BYTES) ? len : HDR_BYTES;
		frame = new[n];
		foreach (frame[k]) frame[k] = 8'($urandom);
		{frame[POS_ETYPE0], frame[POS_ETYPE1]} = ETHERTYPE_V6;
		frame[POS_NXTHDR] = NEXT_HDR_ICMP;
		frame[POS_TYPE] = ICMP_TYPE_REQ;
		if (csum != CSUM_RANDOM) {frame[POS_CSUM0], frame[POS_CSUM1]} = 16'(csum);
		if (flaws & FLAW_ETYPE) begin
			case ($urandom_range(0, 2))
				0: frame[POS_ETYPE0] = other_than(frame[POS_ETYPE0]);
				1: frame[POS_ETYPE1] = other_than(frame[POS_ETYPE1]);
				default: begin
					frame[POS_ETYPE0] = other_than(frame[POS_ETYPE0]);
					frame[POS_ETYPE1] = other_than(frame[POS_ETYPE1]);
				end
			endcase
		end
		if (flaws & FLAW_NEXT_HDR) frame[POS_NXTHDR] = other_than(NEXT_HDR_ICMP);
		if (flaws & FLAW_TYPE) begin
			if ($urandom_range(0, 1)) frame[POS_TYPE] = ICMP_TYPE_RPL;
			else frame[POS_TYPE] = other_than(ICMP_TYPE_REQ);
		end
		for (i = 0; i < len; i++)
			send_byte(frame[i], i == len - 1, (i == HDR_BYTES - 1) ? slot : 1'($urandom));
	endtask

	task automatic drain_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.reply_beats.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int len;
		int round;
		int total_bytes;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		tx_slot_free = 1'b0;
		src_quiet = 0;
		hold_request = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single-byte short frames at the byte extremes
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b0);
		drain_replies();

		// receiver holds off while a reply with payload is offered
		hold_request = 1;
		send_frame(64, 0, 1'b1, 16'hFFFF);
		total_bytes = 66;
		round = 0;

		// short frame, then each reject reason with precedence, then a reply
		while (total_bytes < ITEM_TARGET) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			len = $urandom_range(HDR_BYTES, HDR_BYTES + 4);
			case (round % 6)
				0: begin
					len = $urandom_range(1, HDR_BYTES - 1);
					send_frame(len, 0, 1'b1, CSUM_RANDOM);
				end
				1: send_frame(len, FLAW_ETYPE | FLAW_NEXT_HDR | FLAW_TYPE, 1'b0, CSUM_RANDOM);
				2: send_frame(len, FLAW_NEXT_HDR | FLAW_TYPE, 1'b0, CSUM_RANDOM);
				3: send_frame(len, FLAW_TYPE, 1'b0, CSUM_RANDOM);
				4: send_frame(len, 0, 1'b0, CSUM_RANDOM);
				default: send_frame(len, 0, 1'b1, CSUM_RANDOM);
			endcase
			total_bytes += len;
			round++;
		end
		drain_replies();

		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
